// ===== rtl/core/mlp_pkg.sv =====
package mlp_pkg;

  localparam int MAX_NEURONS = 16;

  typedef enum logic [1:0] {
    OP_WEIGHT = 2'd0,
    OP_BIAS   = 2'd1,
    OP_SAMPLE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  localparam logic [2:0] REG_LAYER_COUNT = 3'd0;
  localparam logic [2:0] REG_INPUT_WIDTH = 3'd1;
  localparam logic [2:0] REG_WIDTH_ONE   = 3'd2;
  localparam logic [2:0] REG_WIDTH_TWO   = 3'd3;
  localparam logic [2:0] REG_WIDTH_THREE = 3'd4;
  localparam logic [2:0] REG_WIDTH_FOUR  = 3'd5;

  typedef struct packed {
    logic [1:0]  operation;
    logic [1:0]  layer_select;
    logic [3:0]  neuron_index;
    logic [3:0]  input_index;
    logic [15:0] value;
    logic        last_sample;
  } in_item_t;

  typedef struct packed {
    logic [3:0] output_index;
    logic [8:0] activation;
    logic       count_error;
    logic       last;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;
  } cfg_item_t;

  // Front-to-back command: either a run start or a count error.
  typedef struct packed {
    logic count_error;
  } cmd_t;

  // Sigmoid table, entry i = round(256 / (1 + exp(-(i - 128) / 16))), nine bits per entry.
  function automatic logic [2303:0] build_sigmoid_table();
    logic [63:0]   e;
    logic [63:0]   d;
    logic [63:0]   r;
    logic [8:0]    q;
    logic [8:0]    pos [129];
    logic [2303:0] tbl;
    begin
      e = 64'd1 << 30;
      for (int k = 0; k <= 128; k++) begin
        d = (64'd1 << 30) + e;
        r = (64'd1 << 38) + (d >> 1);
        q = '0;
        for (int b = 8; b >= 0; b--) begin
          if (r >= (d << b)) begin
            r = r - (d << b);
            q[b] = 1'b1;
          end
        end
        pos[k] = q;
        e = (e * 64'd1008687096 + (64'd1 << 29)) >> 30;
      end
      tbl = '0;
      for (int k = 0; k < 256; k++) begin
        tbl[k * 9 +: 9] = (k >= 128) ? pos[k - 128] : 9'(9'd256 - pos[128 - k]);
      end
      build_sigmoid_table = tbl;
    end
  endfunction

  localparam logic [2303:0] SIGMOID_TABLE = build_sigmoid_table();

endpackage

// ===== rtl/core/mlp_if.sv =====
interface mlp_in_if;
  logic              valid;
  logic              ready;
  mlp_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlp_out_if;
  logic               valid;
  logic               ready;
  mlp_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface mlp_cfg_if;
  logic               valid;
  logic               ready;
  mlp_pkg::cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/mlp_front.sv =====
module mlp_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mlp_pkg::in_item_t in_data,
  input  logic [4:0]        width_in,
  input  logic              q_full,
  output logic              q_push,
  output mlp_pkg::cmd_t     q_cmd,
  input  logic              busy,
  output logic              w_we,
  output logic              b_we,
  output logic              s_we
);
  logic [4:0] samples_seen;
  logic [4:0] seen_inc;
  logic       fire;
  logic       is_sample;

  assign in_ready  = !q_full && !busy;
  assign fire      = in_valid && in_ready;
  assign is_sample = in_data.operation == mlp_pkg::OP_SAMPLE;
  assign w_we = fire && in_data.operation == mlp_pkg::OP_WEIGHT;
  assign b_we = fire && in_data.operation == mlp_pkg::OP_BIAS;
  assign s_we = fire && is_sample;
  assign seen_inc = (samples_seen < 5'd31) ? samples_seen + 5'd1 : samples_seen;
  assign q_push = s_we && in_data.last_sample;
  assign q_cmd.count_error = seen_inc != width_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_seen <= '0;
    end else if (s_we) begin
      samples_seen <= in_data.last_sample ? 5'd0 : seen_inc;
    end
  end
endmodule

// ===== rtl/core/mlp_back.sv =====
module mlp_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  mlp_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               busy,
  input  logic [2:0]         layers,
  input  logic [4:0]         width_in,
  input  logic [4:0]         widths [4],
  input  logic               w_we,
  input  logic               b_we,
  input  logic               s_we,
  input  mlp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mlp_pkg::out_item_t out_data
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ACC  = 5'b00010,
    S_WAIT = 5'b00100,
    S_SIG  = 5'b01000,
    S_EMIT = 5'b10000
  } state_t;

  state_t      state;
  logic [15:0] weight_mem [1024];
  logic [15:0] bias_mem [64];
  logic [15:0] ping [16];
  logic [15:0] pong [16];
  logic [15:0] w_rd;
  logic [15:0] b_rd;
  logic [1:0]  lay;
  logic [3:0]  neu;
  logic [4:0]  inp;
  logic        pp;
  logic [4:0]  cur_w;
  logic [4:0]  cur_out;
  logic        rd_ok;
  logic [3:0]  rd_inp;
  logic [15:0] act_rd;
  logic [31:0] prod;
  logic [39:0] acc;
  logic [7:0]  sig_idx;
  logic [8:0]  sig_val;
  logic [3:0]  emit_n;
  logic [4:0]  final_w;
  logic        emit_now;

  function automatic logic [8:0] act_emit(input logic [3:0] n);
    begin
      act_emit = pp ? pong[n][8:0] : ping[n][8:0];
    end
  endfunction

  assign cur_out = widths[lay];
  assign busy    = state != S_IDLE;
  assign q_pop   = (state == S_IDLE) && q_valid;
  assign emit_now = (state == S_IDLE && q_valid && q_cmd.count_error) ||
                    (state == S_EMIT && (!out_valid || out_ready));

  always_ff @(posedge clk) begin
    if (w_we) begin
      weight_mem[{in_data.layer_select, in_data.neuron_index, in_data.input_index}] <=
        in_data.value;
    end
    if (b_we) begin
      bias_mem[{in_data.layer_select, in_data.neuron_index}] <= in_data.value;
    end
    w_rd <= weight_mem[{lay, neu, rd_inp}];
    b_rd <= bias_mem[{lay, neu}];
  end

  assign rd_inp = inp[3:0];
  assign act_rd = pp ? pong[rd_inp] : ping[rd_inp];
  assign prod   = 32'($signed(act_rd) * $signed(w_rd));

  always_comb begin
    if ($signed(acc) < -40'sd524288) begin
      sig_idx = 8'd0;
    end else if ($signed(acc) >= 40'sd524288) begin
      sig_idx = 8'd255;
    end else begin
      sig_idx = 8'(((acc + 40'd524288) >> 12));
    end
  end

  assign sig_val = mlp_pkg::SIGMOID_TABLE[12'(sig_idx) * 12'd9 +: 9];

  always_ff @(posedge clk) begin
    if (s_we) begin
      ping[in_data.input_index] <= in_data.value;
    end
    if (state == S_SIG) begin
      if (pp) begin
        ping[neu] <= {7'd0, sig_val};
      end else begin
        pong[neu] <= {7'd0, sig_val};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_now) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      lay <= '0; neu <= '0; inp <= '0; pp <= 1'b0; rd_ok <= 1'b0;
      cur_w <= '0; emit_n <= '0; final_w <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            if (q_cmd.count_error) begin
              out_data  <= '{output_index: 4'd0, activation: 9'd0, count_error: 1'b1,
                             last: 1'b1};
            end else begin
              state <= S_WAIT;
              lay <= '0; neu <= '0; inp <= '0; pp <= 1'b0; rd_ok <= 1'b0;
              cur_w <= width_in;
            end
          end
        end
        S_WAIT: begin
          state <= S_ACC;
          inp   <= inp;
        end
        S_ACC: begin
          if (!rd_ok) begin
            acc   <= {{16{b_rd[15]}}, b_rd, 8'd0};
            rd_ok <= 1'b1;
          end else begin
            acc <= acc + {{8{prod[31]}}, prod};
            if (inp + 5'd1 == cur_w) begin
              state <= S_SIG;
            end else begin
              inp   <= inp + 5'd1;
              state <= S_WAIT;
            end
          end
        end
        S_SIG: begin
          rd_ok <= 1'b0;
          inp   <= '0;
          if (5'(neu) + 5'd1 == cur_out) begin
            neu   <= '0;
            pp    <= !pp;
            cur_w <= cur_out;
            if (3'(lay) + 3'd1 == layers) begin
              state   <= S_EMIT;
              final_w <= cur_out;
              emit_n  <= '0;
            end else begin
              lay   <= lay + 2'd1;
              state <= S_WAIT;
            end
          end else begin
            neu   <= neu + 4'd1;
            state <= S_WAIT;
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_data  <= '{output_index: emit_n, activation: act_emit(emit_n),
                           count_error: 1'b0, last: (5'(emit_n) + 5'd1 == final_w)};
            if (5'(emit_n) + 5'd1 == final_w) begin
              state <= S_IDLE;
            end else begin
              emit_n <= emit_n + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/core/mlp_forward_pass_sigmoid_unit.sv =====
// Weight, bias and sample beats are accepted back to back while no run is queued
// or busy. The last sample starts a run in which a single multiply-accumulate
// unit visits every weight, passing a wait and an accumulate state for the bias
// and each weight, a sigmoid state per neuron; input is held off during the run.
module mlp_forward_pass_sigmoid_unit (
  input logic      clk,
  input logic      rst,
  mlp_in_if.sink   in_ch,
  mlp_out_if.source out_ch,
  mlp_cfg_if.sink  cfg
);
  logic [2:0] layer_count;
  logic [4:0] input_width;
  logic [4:0] width_raw [4];
  logic [4:0] widths [4];
  logic [2:0] layers;
  logic [4:0] width_in;
  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       busy;
  logic       w_we, b_we, s_we;
  mlp_pkg::cmd_t q_cmd;
  mlp_pkg::cmd_t q_reg;
  logic       q_valid;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      layer_count <= 3'd2;
      input_width <= 5'd16;
      for (int i = 0; i < 4; i++) width_raw[i] <= 5'd16;
    end else if (cfg.valid) begin
      if (cfg.data.cfg_index == mlp_pkg::REG_LAYER_COUNT) begin
        layer_count <= cfg.data.cfg_data[2:0];
      end else if (cfg.data.cfg_index == mlp_pkg::REG_INPUT_WIDTH) begin
        input_width <= cfg.data.cfg_data[4:0];
      end else if (cfg.data.cfg_index >= mlp_pkg::REG_WIDTH_ONE &&
                   cfg.data.cfg_index <= mlp_pkg::REG_WIDTH_FOUR) begin
        width_raw[2'(cfg.data.cfg_index - mlp_pkg::REG_WIDTH_ONE)] <= cfg.data.cfg_data[4:0];
      end
    end
  end

  always_comb begin
    layers   = (layer_count == 3'd0) ? 3'd1 : (layer_count > 3'd4 ? 3'd4 : layer_count);
    width_in = (input_width == 5'd0) ? 5'd1 :
               (input_width > 5'(mlp_pkg::MAX_NEURONS) ? 5'(mlp_pkg::MAX_NEURONS)
                                                       : input_width);
    for (int i = 0; i < 4; i++) begin
      widths[i] = (width_raw[i] == 5'd0) ? 5'd1 :
                  (width_raw[i] > 5'(mlp_pkg::MAX_NEURONS) ? 5'(mlp_pkg::MAX_NEURONS)
                                                           : width_raw[i]);
    end
  end

  // One-entry command queue between front and back.
  assign q_full = q_valid;
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (q_push) begin
      q_valid <= 1'b1;
      q_reg   <= q_cmd;
    end else if (q_pop) begin
      q_valid <= 1'b0;
    end
  end

  mlp_front u_front (
    .clk, .rst, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
    .width_in, .q_full, .q_push, .q_cmd, .busy, .w_we, .b_we, .s_we
  );

  mlp_back u_back (
    .clk, .rst, .q_valid(q_valid && !busy && (!out_ch.valid || out_ch.ready)),
    .q_cmd(q_reg), .q_pop, .busy, .layers, .width_in, .widths, .w_we, .b_we, .s_we,
    .in_data(in_ch.data), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_data(out_ch.data)
  );

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !(in_ch.valid && in_ch.ready)) else $error("input taken during run");
  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.data.count_error) |-> out_ch.data.last)
    else $error("error result without last");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_valid) else $error("queue overrun");
`endif
endmodule
